[sv/mmhg_pkg.sv]
// Shared constants, types and state encoding for the height-to-gray converter.
package mmhg_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int HEIGHT_W    = 32;
  localparam int TILE_W      = 16;
  localparam int GRAY_W      = 8;
  localparam int THR_W       = 16;
  localparam int NUM_W       = HEIGHT_W + GRAY_W;
  localparam int ADDR_W      = 3;

  localparam logic [TILE_W-1:0] INDEX_MASK = (INDEX_BITS >= TILE_W) ? {TILE_W{1'b1}} :
                                             TILE_W'((64'd1 << INDEX_BITS) - 64'd1);

  localparam logic [HEIGHT_W-1:0] LOWEST_RESET  = 32'h7FFF_FFFF;
  localparam logic [HEIGHT_W-1:0] HIGHEST_RESET = 32'h8000_0000;
  localparam logic [HEIGHT_W-1:0] RANGE_ONE     = 32'h0001_0000;
  localparam logic [THR_W-1:0]    THR_RESET     = 16'd66;
  localparam logic [GRAY_W-1:0]   GRAY_MIN      = 8'd0;
  localparam logic [GRAY_W-1:0]   GRAY_MAX      = 8'd255;

  // Register word index (byte address / 4)
  localparam logic REG_FLAT_THRESHOLD = 1'b0;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/mmhg_extrema.sv]
// Running minimum and maximum of measured heights.
module mmhg_extrema (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           update,
  input  logic                           restart,
  input  logic [mmhg_pkg::HEIGHT_W-1:0]  height,
  output logic [mmhg_pkg::HEIGHT_W-1:0]  lowest,
  output logic [mmhg_pkg::HEIGHT_W-1:0]  highest
);
  import mmhg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest  <= LOWEST_RESET;
      highest <= HIGHEST_RESET;
    end else if (update) begin
      if (restart) begin
        lowest  <= height;
        highest <= height;
      end else begin
        if ($signed(height) < $signed(lowest)) begin
          lowest <= height;
        end
        if ($signed(height) > $signed(highest)) begin
          highest <= height;
        end
      end
    end
  end

endmodule

[sv/mmhg_div.sv]
// Restoring divider: one quotient bit per cycle, numerator low bits shifted in serially.
module mmhg_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mmhg_pkg::NUM_W-1:0]     numer,
  input  logic [mmhg_pkg::HEIGHT_W-1:0]  denom,
  output logic [mmhg_pkg::GRAY_W-1:0]    quotient,
  output mmhg_pkg::div_stat_t            stat
);
  import mmhg_pkg::*;

  localparam int CNT_W = $clog2(GRAY_W);

  logic [HEIGHT_W-1:0] rem;
  logic [HEIGHT_W-1:0] dvs;
  // Holds the numerator low bits at start; quotient bits fill in from the bottom.
  logic [GRAY_W-1:0]   shreg;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [HEIGHT_W:0]   trial;
  logic [HEIGHT_W+1:0] sub;
  logic                fits;

  assign trial = {rem, shreg[GRAY_W-1]};
  assign sub   = {1'b0, trial} - {2'b00, dvs};
  assign fits  = ~sub[HEIGHT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(GRAY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= numer[NUM_W-1:GRAY_W];
      shreg <= numer[GRAY_W-1:0];
      dvs   <= denom;
    end else if (busy) begin
      rem   <= fits ? sub[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];
      shreg <= {shreg[GRAY_W-2:0], fits};
    end
  end

  assign quotient  = shreg;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[sv/minmax_height_to_gray.sv]
// Top level: stream ports, threshold register, sequencer and output register.
// Measure item: no result; the next item can be taken the cycle after.
// Convert item: PREP registers range and offset; SCALE clamps to 0 or 255 or starts the
// 8-step serial divider; DONE loads the result once the output register is free. One item
// is in flight at a time; a finished result waits in the output register meanwhile.
// Reset (rst, synchronous): min at most positive, max at most negative, threshold 66.
module minmax_height_to_gray (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,  // height[31:0], tile_index[47:32]
  input  logic [1:0]                    s_tuser,  // kind[0], first_sample[1]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // out_tile_index[15:0], gray_level[23:16]
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmhg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mmhg_pkg::*;

  state_t              state, state_next;
  logic [THR_W-1:0]    flat_threshold;
  logic [HEIGHT_W-1:0] hreg;
  logic [TILE_W-1:0]   idx;
  logic [HEIGHT_W:0]   rng;
  logic [HEIGHT_W:0]   diff;
  logic [GRAY_W-1:0]   gray;
  logic [TILE_W-1:0]   out_idx;
  logic [GRAY_W-1:0]   out_gray;
  logic                out_valid;

  logic                in_xfer;
  logic                measure;
  logic [HEIGHT_W-1:0] lowest, highest;
  logic                flat;
  logic [HEIGHT_W-1:0] rng_eff;
  logic                diff_le0;
  logic                diff_ge;
  logic [NUM_W-1:0]    numer;
  logic                div_start;
  logic [GRAY_W-1:0]   quotient;
  div_stat_t           div_stat;
  logic                gray_load;
  logic [GRAY_W-1:0]   gray_next;
  logic                out_load;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_FLAT_THRESHOLD) ? {16'd0, flat_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1] == REG_FLAT_THRESHOLD) begin
      flat_threshold <= pwdata[THR_W-1:0];
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign measure  = in_xfer && (s_tuser[0] == KIND_MEASURE);

  mmhg_extrema u_extrema (
    .clk     (clk),
    .rst     (rst),
    .update  (measure),
    .restart (s_tuser[1]),
    .height  (s_tdata[HEIGHT_W-1:0]),
    .lowest  (lowest),
    .highest (highest)
  );

  // Range and offset, both at 33 bits signed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hreg <= s_tdata[HEIGHT_W-1:0];
      idx  <= s_tdata[47:32] & INDEX_MASK;
    end
    if (state == ST_PREP) begin
      rng  <= {highest[HEIGHT_W-1], highest} - {lowest[HEIGHT_W-1], lowest};
      diff <= {hreg[HEIGHT_W-1], hreg} - {lowest[HEIGHT_W-1], lowest};
    end
    if (gray_load) begin
      gray <= gray_next;
    end
  end

  assign flat     = $signed(rng) < $signed({{(HEIGHT_W + 1 - THR_W){1'b0}}, flat_threshold});
  assign rng_eff  = flat ? RANGE_ONE : rng[HEIGHT_W-1:0];
  assign diff_le0 = diff[HEIGHT_W] || (diff == '0);
  assign diff_ge  = diff[HEIGHT_W-1:0] >= rng_eff;
  // diff * 255 as (diff << 8) - diff
  assign numer    = {diff[HEIGHT_W-1:0], {GRAY_W{1'b0}}} -
                    {{GRAY_W{1'b0}}, diff[HEIGHT_W-1:0]};

  mmhg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (rng_eff),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    gray_load  = 1'b0;
    gray_next  = quotient;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer && s_tuser[0] == KIND_CONVERT) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (diff_le0) begin
          gray_load  = 1'b1;
          gray_next  = GRAY_MIN;
          state_next = ST_DONE;
        end else if (diff_ge) begin
          gray_load  = 1'b1;
          gray_next  = GRAY_MAX;
          state_next = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          gray_load  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free or draining
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx  <= idx;
      out_gray <= gray;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_gray, out_idx};

endmodule

[dv/tb.sv]
// Self-checking stream testbench for the min/max height-to-gray converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmhg_pkg::*;

  localparam int                HOLD_CYCLES = 400;
  localparam int                STALL_LIMIT = 3000;
  localparam int                SETTLE      = 20;
  localparam logic [ADDR_W-1:0] THR_ADDR    = ADDR_W'(4 * int'(REG_FLAT_THRESHOLD));

  typedef struct {
    logic              kind;
    logic              first;
    logic [31:0]       height;
    logic [TILE_W-1:0] tile;
  } sample_t;

  typedef struct {
    logic [TILE_W-1:0] tile;
    logic [GRAY_W-1:0] gray;
  } gray_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // height[31:0], tile_index[47:32]
  logic [1:0]  s_tuser = '0;   // kind[0], first_sample[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // out_tile_index[15:0], gray_level[23:16]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  minmax_height_to_gray i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  sample_t height_q[$];
  gray_t   gray_due[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int queued       = 0;
  int taken        = 0;
  int n_measure    = 0;
  int n_results    = 0;
  int n_flat       = 0;
  int n_clamped    = 0;
  int errors       = 0;
  int stall_cnt    = 0;
  logic s_fire     = 1'b0;

  // Converter state as the testbench tracks it
  logic signed [31:0] run_min;
  logic signed [31:0] run_max;
  logic [THR_W-1:0]   flat_thr;

  function automatic logic [GRAY_W-1:0] predict_gray(input logic signed [31:0] h,
                                                     output bit flat, output bit clamped);
    logic signed [32:0] span;
    logic signed [32:0] diff;
    logic signed [40:0] num;
    logic signed [40:0] quo;
    span = {run_max[31], run_max} - {run_min[31], run_min};
    flat = span < $signed({17'b0, flat_thr});
    if (flat) span = 33'sd65536;
    diff = {h[31], h} - {run_min[31], run_min};
    clamped = 1'b1;
    if (diff <= 0) return GRAY_MIN;
    if (diff >= span) return GRAY_MAX;
    clamped = 1'b0;
    num = diff;
    num = num * 41'sd255;
    quo = num / span;
    return quo[GRAY_W-1:0];
  endfunction

  // Stimulus driver
  always @(negedge clk) begin
    sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (height_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = height_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.tile, nxt.height};
        s_tuser  <= {nxt.first, nxt.kind};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with random back-pressure and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    gray_t   want;
    logic signed [31:0] h;
    bit      flat;
    bit      clamped;
    s_fire <= s_tvalid && s_tready;
    if (rst) begin
      run_min  = LOWEST_RESET;
      run_max  = HIGHEST_RESET;
      flat_thr = THR_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == THR_ADDR)
        flat_thr = pwdata[THR_W-1:0];
      if (m_tvalid && m_tready) begin
        if (gray_due.size() == 0) begin
          $error("unexpected result tile=%0h gray=%0d", m_tdata[15:0], m_tdata[23:16]);
          errors++;
        end else begin
          want = gray_due.pop_front();
          n_results++;
          if (m_tdata[15:0] !== want.tile) begin
            $error("out_tile_index: expected %0h, got %0h", want.tile, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[23:16] !== want.gray) begin
            $error("gray_level: expected %0d, got %0d", want.gray, m_tdata[23:16]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        taken++;
        h = s_tdata[31:0];
        if (s_tuser[0] == KIND_MEASURE) begin
          n_measure++;
          if (s_tuser[1]) begin
            run_min = h;
            run_max = h;
          end else begin
            if (h < run_min) run_min = h;
            if (h > run_max) run_max = h;
          end
        end else begin
          want.gray = predict_gray(h, flat, clamped);
          want.tile = s_tdata[47:32] & INDEX_MASK;
          gray_due.push_back(want);
          n_flat    += flat;
          n_clamped += clamped;
        end
      end
    end
  end

  // Watchdog: no transfer for too long while work is outstanding
  always @(posedge clk) begin
    if ((taken != queued || gray_due.size() != 0) &&
        !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", stall_cnt);
        $display("TEST FAILED");
        $finish;
      end
    end else begin
      stall_cnt = 0;
    end
  end

  task automatic push_item(input logic kind, input logic first, input logic [31:0] h,
                           input logic [TILE_W-1:0] tile);
    sample_t s;
    s.kind   = kind;
    s.first  = first;
    s.height = h;
    s.tile   = tile;
    height_q.push_back(s);
    queued++;
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every item and result, then let trailing measure items settle
  task automatic wait_drained();
    while (taken != queued || gray_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One measure pass over a random band followed by conversions and, sometimes, noise items
  task automatic queue_frame(input int thr);
    longint          span;
    longint          base;
    longint          h;
    longint unsigned r;
    int              n_in;
    int              n_conv;
    int              pick;
    case ($urandom_range(0, 9))
      0, 1, 2: span = $urandom_range(0, 255);
      3:       span = (thr == 0) ? $urandom_range(0, 1) : thr - 1 + $urandom_range(0, 2);
      4, 5, 6: span = $urandom_range(256, 1 << 24);
      7, 8:    span = longint'($urandom);
      default: span = 64'd4294967295 - $urandom_range(0, 3);
    endcase
    r    = {$urandom, $urandom};
    base = -64'sd2147483648 + longint'(r % (64'd4294967296 - span));
    // mostly restart; sometimes fold into the previous extremes
    push_item(KIND_MEASURE, $urandom_range(0, 7) != 0,
              $urandom_range(0, 1) ? base[31:0] : 32'(base + span), 16'($urandom));
    n_in = $urandom_range(0, 5);
    repeat (n_in) begin
      r = {$urandom, $urandom};
      h = base + longint'(r % (span + 1));
      push_item(KIND_MEASURE, 1'b0, h[31:0], 16'($urandom));
    end
    h = base + span;
    push_item(KIND_MEASURE, 1'b0, h[31:0], 16'($urandom));
    push_item(KIND_MEASURE, 1'b0, base[31:0], 16'($urandom));
    n_conv = $urandom_range(1, 12);
    repeat (n_conv) begin
      r    = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      case (pick)
        0:       h = clip32(base - $urandom_range(1, 1 << 17));
        1:       h = clip32(base + span + $urandom_range(1, 1 << 17));
        2:       h = $urandom_range(0, 1) ? base : base + span;
        3:       h = clip32(base + $urandom_range(0, 1 << 17));
        default: h = base + longint'(r % (span + 1));
      endcase
      push_item(KIND_CONVERT, 1'($urandom_range(0, 1)), h[31:0], 16'($urandom));
    end
    // noise: any kind, any flag, any height
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                  16'($urandom));
  endtask

  initial begin
    int thr_set[3];
    int stop_at;
    thr_set[0] = 0;
    thr_set[1] = 65535;
    thr_set[2] = $urandom_range(1, 65534);
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset threshold
    src_idle_pct = 10;
    snk_idle_pct = 63;
    push_item(KIND_CONVERT, 1'b1, 32'h1234_5678, 16'hFFFF);  // before any measure
    push_item(KIND_CONVERT, 1'b0, 32'h7FFF_FFFF, 16'h0000);
    push_item(KIND_MEASURE, 1'b0, 32'h0000_0000, 16'h0001);  // folds into reset extremes
    push_item(KIND_CONVERT, 1'b0, 32'h0000_0000, 16'h0002);
    push_item(KIND_CONVERT, 1'b0, 32'h0000_8000, 16'h0003);
    push_item(KIND_CONVERT, 1'b0, 32'h0001_0000, 16'h0004);
    push_item(KIND_MEASURE, 1'b0, 32'h8000_0000, 16'h0005);
    push_item(KIND_MEASURE, 1'b0, 32'h7FFF_FFFF, 16'h0006);  // full 33-bit range
    push_item(KIND_CONVERT, 1'b0, 32'h8000_0000, 16'h0007);
    push_item(KIND_CONVERT, 1'b0, 32'h7FFF_FFFF, 16'h0008);
    push_item(KIND_CONVERT, 1'b0, 32'h0000_0000, 16'h0009);
    push_item(KIND_CONVERT, 1'b0, 32'hFFFF_FFFF, 16'h000A);
    push_item(KIND_MEASURE, 1'b1, 32'd100, 16'h000B);        // restart
    push_item(KIND_MEASURE, 1'b0, 32'd165, 16'h000C);        // range just under threshold
    push_item(KIND_CONVERT, 1'b0, 32'd65635, 16'h000D);
    push_item(KIND_CONVERT, 1'b0, 32'd65636, 16'h000E);
    push_item(KIND_CONVERT, 1'b0, 32'd50, 16'h000F);
    push_item(KIND_MEASURE, 1'b0, 32'd166, 16'h0010);        // range at threshold
    push_item(KIND_CONVERT, 1'b0, 32'd166, 16'h0011);
    push_item(KIND_CONVERT, 1'b0, 32'd133, 16'h0012);
    push_item(KIND_CONVERT, 1'b1, 32'd120, 16'h0013);        // flag ignored on convert
    push_item(KIND_MEASURE, 1'b1, 32'hFFFF_FFFB, 16'h0014);
    push_item(KIND_CONVERT, 1'b0, 32'hFFFF_FFFB, 16'h0015);
    push_item(KIND_CONVERT, 1'b0, 32'hFFFF_FFFC, 16'hFFFF);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 63 : 0;
      snk_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 10 : 0;
      apb_write(THR_ADDR, 32'(thr_set[ph]));
      stop_at = queued + 570;
      // long sink hold-off so the converter backs up into its input
      if (ph == 0) hold_reqs++;
      while (queued < stop_at) queue_frame(thr_set[ph]);
      wait_drained();
    end

    if (gray_due.size() != 0) errors++;
    $display("Covered %0d samples (%0d measure), %0d gray results checked,", queued,
             n_measure, n_results);
    $display("  %0d on a flat range, %0d clamped, thresholds 66/0/65535/%0d.", n_flat,
             n_clamped, thr_set[2]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
